// ----- src/pdm_pkg.sv -----
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, register indexes and constants of the PID motor drive core.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int GAIN_W   = 16;
    localparam int CENTER_W = 11;
    localparam int SPAN_W   = 10;
    localparam int IN_W     = 16;
    localparam int ERR_W    = 17;
    localparam int DER_W    = 18;
    localparam int MA_W     = 17;
    localparam int PIDC_W   = 10;
    localparam int CMD_W    = 13;
    localparam int LOOP_W   = 32;
    localparam int SCALE_SH = 8;
    localparam int SP_W     = 20;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [IDX_W-1:0] REG_DRIVE_CENTER = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_SPAN   = 3'd4;

    localparam logic [GAIN_W-1:0]   RST_GAIN_P       = 16'd4096;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I       = 16'd410;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D       = 16'd41;
    localparam logic [CENTER_W-1:0] RST_DRIVE_CENTER = 11'd737;
    localparam logic [SPAN_W-1:0]   RST_DRIVE_SPAN   = 10'd500;

    // Unit loop output in Q8.8; beyond it the command clamp always wins.
    localparam logic signed [PIDC_W-1:0] PIDC_LIM = 10'sd256;
    localparam logic signed [SP_W-1:0]   TRUNC_BIAS = 20'sd255;

    typedef struct packed {
        logic signed [IN_W-1:0] setpoint;
        logic signed [IN_W-1:0] measured;
    } t_in_word;

    typedef struct packed {
        logic signed [CMD_W-1:0]  drive_command;
        logic signed [LOOP_W-1:0] loop_output;
    } t_out_word;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [CENTER_W-1:0] drive_center;
        logic [SPAN_W-1:0]   drive_span;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_MUL_D,
        ST_ACC_D,
        ST_REDUCE,
        ST_SCALE,
        ST_OUT
    } t_state;

endpackage

// ----- src/pdm_regs.sv -----
// ----------------------------------------------------------------------------
// pdm_regs
// APB-style configuration registers: gains, drive center and drive span.
// ----------------------------------------------------------------------------
module pdm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pdm_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [pdm_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [pdm_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready,
    output pdm_pkg::t_cfg                 o_cfg
);
    import pdm_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx    = i_paddr[PADDR_W-1:2];
    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p       <= RST_GAIN_P;
            r_cfg.gain_i       <= RST_GAIN_I;
            r_cfg.gain_d       <= RST_GAIN_D;
            r_cfg.drive_center <= RST_DRIVE_CENTER;
            r_cfg.drive_span   <= RST_DRIVE_SPAN;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:       r_cfg.gain_p       <= i_pwdata[GAIN_W-1:0];
                REG_GAIN_I:       r_cfg.gain_i       <= i_pwdata[GAIN_W-1:0];
                REG_GAIN_D:       r_cfg.gain_d       <= i_pwdata[GAIN_W-1:0];
                REG_DRIVE_CENTER: r_cfg.drive_center <= i_pwdata[CENTER_W-1:0];
                REG_DRIVE_SPAN:   r_cfg.drive_span   <= i_pwdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GAIN_P:       o_prdata = PDATA_W'(r_cfg.gain_p);
            REG_GAIN_I:       o_prdata = PDATA_W'(r_cfg.gain_i);
            REG_GAIN_D:       o_prdata = PDATA_W'(r_cfg.gain_d);
            REG_DRIVE_CENTER: o_prdata = PDATA_W'(r_cfg.drive_center);
            REG_DRIVE_SPAN:   o_prdata = PDATA_W'(r_cfg.drive_span);
            default:          o_prdata = '0;
        endcase
    end

endmodule

// ----- src/pdm_mul.sv -----
// ----------------------------------------------------------------------------
// pdm_mul
// Shared signed multiplier with a registered product and a load enable.
// ----------------------------------------------------------------------------
module pdm_mul #(
    parameter int B_W = 25
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [pdm_pkg::MA_W-1:0]   i_a,
    input  logic signed [B_W-1:0]             i_b,
    output logic signed [pdm_pkg::MA_W+B_W-1:0] o_prod
);
    import pdm_pkg::*;

    logic signed [MA_W+B_W-1:0] r_prod;
    logic signed [MA_W+B_W-1:0] n_prod;

    assign n_prod = (MA_W+B_W)'(i_a) * (MA_W+B_W)'(i_b);
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

endmodule

// ----- src/pid_motor_drive_core.sv -----
// ----------------------------------------------------------------------------
// pid_motor_drive_core
// Fixed-point PID speed controller that produces a clamped motor command.
// ----------------------------------------------------------------------------
// Each input word (setpoint, measured; signed Q8.8) is processed on its own and
// yields one output word with the clamped motor command and the Q8.8 loop
// output. The core takes one word at a time: a small sequencer steps
// through ten states (idle, prepare, four multiply states, the last accumulate,
// reduce, scale and output), running the single 17-bit by 18-bit multiplier five
// times per word (P, the low and high halves of the integral, D, and the
// command scaling). The input is stalled until the result has been loaded into
// the output register, and the output state waits as long as a previous word
// is still held there. A finished word waits in that register while the next
// word is accepted. Configuration writes belong in idle periods.
module pid_motor_drive_core #(
    parameter int GAIN_FRAC_BITS = 12,
    parameter int SUM_WIDTH      = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pdm_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pdm_pkg::t_out_word            o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdm_pkg::PADDR_W-1:0]   paddr,
    input  logic [pdm_pkg::PDATA_W-1:0]   pwdata,
    output logic [pdm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import pdm_pkg::*;

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int MB_W  = (HI_W + 1 > DER_W) ? HI_W + 1 : DER_W;
    localparam int PW    = MA_W + MB_W;
    localparam int ACC_W = SUM_WIDTH + 18;

    localparam logic signed [ACC_W-1:0] LOOP_MAX = ACC_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [ACC_W-1:0] LOOP_MIN = ACC_W'(signed'(32'h8000_0000));
    localparam logic signed [ACC_W-1:0] PIDC_MAX = ACC_W'(PIDC_LIM);
    localparam logic signed [ACC_W-1:0] PIDC_MIN = -ACC_W'(PIDC_LIM);

    t_cfg w_cfg;

    t_state r_state;
    t_state n_state;

    logic signed [ERR_W-1:0]     r_err;
    logic signed [ERR_W-1:0]     r_last_err;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [DER_W-1:0]     r_deriv;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [LOOP_W-1:0]    r_pid;
    logic signed [PIDC_W-1:0]    r_pidc;
    t_out_word                   r_out;
    logic                        r_out_valid;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_mul_en;
    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [PW-1:0]     w_prod;
    logic                     w_acc_clr;
    logic                     w_acc_add;
    logic                     w_acc_shift;

    logic signed [SUM_WIDTH:0]   w_sum_ext;
    logic signed [SUM_WIDTH-1:0] w_sum_sat;
    logic signed [ACC_W-1:0]     w_prod_ext;
    logic signed [ACC_W-1:0]     w_term;
    logic signed [ACC_W-1:0]     w_floor;
    logic signed [SP_W-1:0]      w_scaled;
    logic signed [SP_W-1:0]      w_biased;
    logic signed [SP_W-1:0]      w_quot;
    logic signed [CMD_W-1:0]     w_cmd;
    logic signed [CMD_W-1:0]     w_lim_hi;
    logic signed [CMD_W-1:0]     w_lim_lo;

    pdm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    pdm_mul #(
        .B_W (MB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Integral update with saturation; one extra bit catches the overflow.
    assign w_sum_ext = (SUM_WIDTH+1)'(r_sum) + (SUM_WIDTH+1)'(r_err);
    always_comb begin
        if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
            w_sum_sat = {w_sum_ext[SUM_WIDTH], {(SUM_WIDTH-1){~w_sum_ext[SUM_WIDTH]}}};
        end else begin
            w_sum_sat = w_sum_ext[SUM_WIDTH-1:0];
        end
    end

    assign w_prod_ext = ACC_W'(w_prod);
    assign w_term     = w_acc_shift ? (w_prod_ext <<< LO_W) : w_prod_ext;
    assign w_floor    = r_acc >>> GAIN_FRAC_BITS;

    // Division by 256 truncating toward zero: bias negative products first.
    assign w_scaled = SP_W'(w_prod);
    assign w_biased = w_scaled + (w_scaled[SP_W-1] ? TRUNC_BIAS : '0);
    assign w_quot   = w_biased >>> SCALE_SH;
    assign w_cmd    = CMD_W'(w_cfg.drive_center) + CMD_W'(w_quot);
    assign w_lim_hi = CMD_W'(w_cfg.drive_center) + CMD_W'(w_cfg.drive_span);
    assign w_lim_lo = CMD_W'(w_cfg.drive_center) - CMD_W'(w_cfg.drive_span);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept) n_state = ST_PREP;
            ST_PREP:    n_state = ST_MUL_P;
            ST_MUL_P:   n_state = ST_MUL_ILO;
            ST_MUL_ILO: n_state = ST_MUL_IHI;
            ST_MUL_IHI: n_state = ST_MUL_D;
            ST_MUL_D:   n_state = ST_ACC_D;
            ST_ACC_D:   n_state = ST_REDUCE;
            ST_REDUCE:  n_state = ST_SCALE;
            ST_SCALE:   n_state = ST_OUT;
            ST_OUT:     if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands and accumulator control. Each product is added in the
    // cycle after it is issued, since the multiplier output is registered.
    always_comb begin
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_acc_clr   = 1'b0;
        w_acc_add   = 1'b0;
        w_acc_shift = 1'b0;
        unique case (r_state)
            ST_MUL_P: begin
                w_mul_en  = 1'b1;
                w_mul_a   = MA_W'(w_cfg.gain_p);
                w_mul_b   = MB_W'(r_err);
                w_acc_clr = 1'b1;
            end
            ST_MUL_ILO: begin
                w_mul_en  = 1'b1;
                w_mul_a   = MA_W'(w_cfg.gain_i);
                w_mul_b   = MB_W'(r_sum[LO_W-1:0]);
                w_acc_add = 1'b1;
            end
            ST_MUL_IHI: begin
                w_mul_en  = 1'b1;
                w_mul_a   = MA_W'(w_cfg.gain_i);
                w_mul_b   = MB_W'(signed'(r_sum[SUM_WIDTH-1:LO_W]));
                w_acc_add = 1'b1;
            end
            ST_MUL_D: begin
                w_mul_en    = 1'b1;
                w_mul_a     = MA_W'(w_cfg.gain_d);
                w_mul_b     = MB_W'(r_deriv);
                w_acc_add   = 1'b1;
                w_acc_shift = 1'b1;
            end
            ST_ACC_D: begin
                w_acc_add = 1'b1;
            end
            ST_SCALE: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA_W'(w_cfg.drive_span);
                w_mul_b  = MB_W'(r_pidc);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_sum      <= '0;
        end else if (r_state == ST_PREP) begin
            r_last_err <= r_err;
            r_sum      <= w_sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= ERR_W'(i_in_word.setpoint) - ERR_W'(i_in_word.measured);
        end
        if (r_state == ST_PREP) begin
            r_deriv <= DER_W'(r_err) - DER_W'(r_last_err);
        end
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (w_acc_add) begin
            r_acc <= r_acc + w_term;
        end
        if (r_state == ST_REDUCE) begin
            if (w_floor > LOOP_MAX) begin
                r_pid <= LOOP_W'(LOOP_MAX);
            end else if (w_floor < LOOP_MIN) begin
                r_pid <= LOOP_W'(LOOP_MIN);
            end else begin
                r_pid <= LOOP_W'(w_floor);
            end
            if (w_floor > PIDC_MAX) begin
                r_pidc <= PIDC_LIM;
            end else if (w_floor < PIDC_MIN) begin
                r_pidc <= -PIDC_LIM;
            end else begin
                r_pidc <= PIDC_W'(w_floor);
            end
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out.drive_command <= w_cmd;
            r_out.loop_output   <= r_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_PREP))
        else $error("accepted word did not start the sequence");

    a_pidc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE) |-> (r_pidc <= PIDC_LIM && r_pidc >= -PIDC_LIM))
        else $error("clipped loop output out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished word not presented");

    a_cmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free)
            |-> (w_cmd <= w_lim_hi && w_cmd >= w_lim_lo))
        else $error("motor command outside center plus or minus span");

endmodule

// ----- tb/sv/pid_motor_drive_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_drive_core_tb
// Self-checking testbench for the PID motor drive core.
// ----------------------------------------------------------------------------
// Words are sent through the valid/stall input channel while a local model of
// the controller predicts the command and loop output of each accepted word.
// A checker compares every accepted output word with the oldest prediction.
// Phases with different register settings cover field extremes, command
// clamping, zero span, unused register addresses, random words, long output
// back-pressure, and a strongly wound-up integral in both directions.
// ----------------------------------------------------------------------------
module pid_motor_drive_core_tb;
    import pdm_pkg::*;

    localparam int     FRAC_BITS   = 12;
    localparam int     INTEG_W     = 32;
    localparam longint INTEG_MAX   = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN   = -INTEG_MAX - 1;
    localparam longint LOOP_MAX    = longint'(2147483647);
    localparam longint LOOP_MIN    = -LOOP_MAX - 1;
    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     HOLD_CYCLES = 300;

    // Addresses past the register list; writes there must change nothing.
    localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_word;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Model state and register copies.
    longint integ_sum;
    longint prev_err;
    int     cfg_gp;
    int     cfg_gi;
    int     cfg_gd;
    int     cfg_center;
    int     cfg_span;

    t_out_word drive_exp_q[$];
    t_out_word want;

    int  err_cnt;
    int  words_sent;
    int  words_checked;
    int  cfg_count;
    int  cycle_cnt;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_req;
    int  hold_cnt;
    int  burst_cnt;
    bit  stall_next;

    pid_motor_drive_core #(
        .GAIN_FRAC_BITS(FRAC_BITS),
        .SUM_WIDTH     (INTEG_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Computes the expected output word and advances the controller state.
    function automatic t_out_word predict_drive(input logic signed [IN_W-1:0] sp,
                                                input logic signed [IN_W-1:0] ms);
        longint    e;
        longint    d;
        longint    acc;
        longint    pid;
        longint    cmd;
        t_out_word w;
        e = longint'(sp) - longint'(ms);
        integ_sum = integ_sum + e;
        if (integ_sum > INTEG_MAX) integ_sum = INTEG_MAX;
        else if (integ_sum < INTEG_MIN) integ_sum = INTEG_MIN;
        d = e - prev_err;
        prev_err = e;
        acc = longint'(cfg_gp) * e + longint'(cfg_gi) * integ_sum + longint'(cfg_gd) * d;
        // Arithmetic shift of a signed value floors toward minus infinity.
        pid = acc >>> FRAC_BITS;
        if (pid > LOOP_MAX) pid = LOOP_MAX;
        else if (pid < LOOP_MIN) pid = LOOP_MIN;
        // Signed division truncates toward zero.
        cmd = longint'(cfg_center) + (pid * longint'(cfg_span)) / 256;
        if (cmd > longint'(cfg_center + cfg_span)) cmd = longint'(cfg_center + cfg_span);
        else if (cmd < longint'(cfg_center - cfg_span)) cmd = longint'(cfg_center - cfg_span);
        w.drive_command = cmd[CMD_W-1:0];
        w.loop_output   = pid[LOOP_W-1:0];
        return w;
    endfunction

    // Zero, all ones, or a random value of the given width.
    function automatic int rand_field(input int width);
        int top;
        top = (1 << width) - 1;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GAIN_P:       cfg_gp     = int'(value[GAIN_W-1:0]);
            REG_GAIN_I:       cfg_gi     = int'(value[GAIN_W-1:0]);
            REG_GAIN_D:       cfg_gd     = int'(value[GAIN_W-1:0]);
            REG_DRIVE_CENTER: cfg_center = int'(value[CENTER_W-1:0]);
            REG_DRIVE_SPAN:   cfg_span   = int'(value[SPAN_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all five registers; the bits above each field carry random junk.
    task automatic apply_cfg(input int gp, input int gi, input int gd,
                             input int center, input int span);
        apply_one(REG_GAIN_P, gp, GAIN_W);
        apply_one(REG_GAIN_I, gi, GAIN_W);
        apply_one(REG_GAIN_D, gd, GAIN_W);
        apply_one(REG_DRIVE_CENTER, center, CENTER_W);
        apply_one(REG_DRIVE_SPAN, span, SPAN_W);
        cfg_count++;
    endtask

    task automatic apply_one(input logic [IDX_W-1:0] idx, input int field, input int width);
        logic [PDATA_W-1:0] junk;
        junk = $urandom;
        apply_write_masked(idx, (junk << width) | PDATA_W'(field));
    endtask

    task automatic apply_write_masked(input logic [IDX_W-1:0] idx,
                                      input logic [PDATA_W-1:0] value);
        apb_write(idx, value);
    endtask

    task automatic send_word(input logic signed [IN_W-1:0] sp,
                             input logic signed [IN_W-1:0] ms);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= {sp, ms};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        drive_exp_q.push_back(predict_drive(sp, ms));
        words_sent++;
    endtask

    // Drops valid and waits until every predicted word has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_exp_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        send_word(16'sh0000, 16'sh0000);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sh8000);
        send_word(16'sh8000, 16'sh0000);
        send_word(16'sh0000, 16'sh8000);
        send_word(16'sh5555, 16'shAAAA);
        send_word(16'shAAAA, 16'sh5555);
        send_word(16'sh0001, 16'sh0000);
        send_word(16'shFFFF, 16'sh0000);
    endtask

    task automatic test_zero_span();
        wait_idle();
        apply_cfg(0, 0, 0, 1234, 0);
        send_word(16'sh1234, 16'sh0000);
        send_word(16'sh8000, 16'sh7FFF);
        wait_idle();
        // Large gains but no span: the command must still sit at the center.
        apply_cfg(65535, 65535, 65535, 2047, 0);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
    endtask

    task automatic test_command_limits();
        wait_idle();
        apply_cfg(65535, 0, 65535, 2047, 1023);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        wait_idle();
        apply_cfg(65535, 0, 0, 0, 1023);
        send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh8000);
        // Small errors still drive the command to the clamps at this proportional gain.
        send_word(16'sh0025, 16'sh0000);
        send_word(16'shFFDB, 16'sh0000);
    endtask

    task automatic test_unused_regs();
        logic [IDX_W-1:0] idx;
        wait_idle();
        for (idx = REG_UNUSED_FIRST; idx != REG_UNUSED_FIRST - 1; idx++) begin
            apb_write(idx, $urandom);
            if (idx == REG_UNUSED_LAST) break;
        end
        send_word(16'sh0100, 16'shFF00);
        send_word(16'shFF00, 16'sh0100);
    endtask

    task automatic test_random_phases();
        int                     ph;
        int                     n;
        logic signed [IN_W-1:0] sp;
        logic signed [IN_W-1:0] ms;
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            apply_cfg(rand_field(GAIN_W), rand_field(GAIN_W), rand_field(GAIN_W),
                      rand_field(CENTER_W), rand_field(SPAN_W));
            for (n = 0; n < 60; n++) begin
                if (n % 20 == 0) begin
                    tx_idle_en = ($urandom_range(0, 2) != 0);
                    rx_idle_en = ($urandom_range(0, 2) != 0);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        sp = IN_W'($urandom);
                        ms = IN_W'($urandom);
                    end
                    3: begin
                        sp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        ms = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    default: begin
                        // Measured speed tracking the target closely.
                        sp = IN_W'($urandom_range(0, 16000) - 8000);
                        ms = IN_W'(sp + ($urandom_range(0, 600) - 300));
                    end
                endcase
                send_word(sp, ms);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int n;
        wait_idle();
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (n = 0; n < 10; n++) send_word(IN_W'($urandom), IN_W'($urandom));
        tx_idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        int n;
        for (n = 0; n < 6; n++) begin
            send_word(IN_W'($urandom_range(0, 4000) - 2000), IN_W'($urandom));
        end
        wait_idle();
        for (n = 0; n < 6; n++) begin
            send_word(IN_W'($urandom), IN_W'($urandom_range(0, 4000) - 2000));
        end
    endtask

    // Winds the integral far up with the largest error, then far back down.
    // A big integral gain pushes the loop output well past the command clamps.
    task automatic test_integral_windup();
        int n;
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        apply_cfg(rand_field(GAIN_W), 65535, rand_field(GAIN_W),
                  rand_field(CENTER_W), rand_field(SPAN_W));
        for (n = 0; n < 24; n++) send_word(16'sh7FFF, 16'sh8000);
        for (n = 0; n < 24; n++) send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh0000, 16'sh0000);
    endtask

    // Receiver stall: random bursts, or one long hold on request.
    initial begin
        i_out_stall = 1'b0;
        hold_cnt    = 0;
        burst_cnt   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                stall_next = 1'b1;
            end else if (burst_cnt > 0) begin
                burst_cnt--;
                stall_next = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                burst_cnt  = $urandom_range(1, 14) - 1;
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_out_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_exp_q.size() == 0) begin
                $display("%0t: output word with nothing expected: cmd %0d loop %0d",
                         $realtime, o_out_word.drive_command, o_out_word.loop_output);
                err_cnt++;
            end else begin
                want = drive_exp_q.pop_front();
                words_checked++;
                if (o_out_word.drive_command !== want.drive_command) begin
                    $display("%0t: drive_command expected %0d actual %0d",
                             $realtime, want.drive_command, o_out_word.drive_command);
                    err_cnt++;
                end
                if (o_out_word.loop_output !== want.loop_output) begin
                    $display("%0t: loop_output expected %0d actual %0d",
                             $realtime, want.loop_output, o_out_word.loop_output);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_cnt       = 0;
        words_sent    = 0;
        words_checked = 0;
        cfg_count     = 1;
        cycle_cnt     = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        integ_sum     = 0;
        prev_err      = 0;
        cfg_gp        = int'(RST_GAIN_P);
        cfg_gi        = int'(RST_GAIN_I);
        cfg_gd        = int'(RST_GAIN_D);
        cfg_center    = int'(RST_DRIVE_CENTER);
        cfg_span      = int'(RST_DRIVE_SPAN);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_field_extremes();
        test_zero_span();
        test_command_limits();
        test_unused_regs();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        test_integral_windup();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (drive_exp_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $realtime, drive_exp_q.size());
            err_cnt++;
        end
        $display("Summary: %0d words sent, %0d output words checked, %0d register settings.",
                 words_sent, words_checked, cfg_count);
        $display("Summary: field extremes, clamps, zero span, unused addresses, %s",
                 "back-pressure and a wound-up integral in both directions.");
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- pid_motor_drive_core.f -----
src/pdm_pkg.sv
src/pdm_regs.sv
src/pdm_mul.sv
src/pid_motor_drive_core.sv
tb/sv/pid_motor_drive_core_tb.sv
